FILE: rtl/core/mrw_pkg.sv
// mrw_pkg: shared constants, verdict codes and the modular add helper
// for the miller-rabin witness test; no dependencies
package mrw_pkg;

	localparam int WIDTH = 64;
	localparam int CW    = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [CW-1:0]    cnt_t;

	typedef enum logic [1:0] {
		VERDICT_PRIME     = 2'd0,
		VERDICT_COMPOSITE = 2'd1,
		VERDICT_REJECT    = 2'd2
	} verdict_t;

	// (a + b) mod n for a, b < n
	function automatic word_t mrw_add_mod(input word_t a, input word_t b, input word_t n);
		logic [WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[WIDTH-1:0];
	endfunction

endpackage

FILE: rtl/core/miller_rabin_witness_test.sv
// miller_rabin_witness_test: one miller-rabin round per transfer, top level
// steps: witness reduction mod n, splitting n-1 into u * 2^t, then up to
// W + popcount(u) + t serial modular products, W = 64; an even candidate or
// 1 skips straight to a reject verdict
// one item at a time; a new item is taken while the previous verdict waits
// in the output register
// arst_n clears control state asynchronously; depends on mrw_pkg, mrw_modmul
module miller_rabin_witness_test (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [mrw_pkg::WIDTH-1:0]  candidate,
	input  logic [mrw_pkg::WIDTH-1:0]  witness,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [1:0]                 verdict
);
	import mrw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_REDUCE, S_SPLIT, S_POW_SQ, S_POW_SQ_W, S_POW_MUL, S_POW_MUL_W,
		S_SQ_CHK, S_SQ_W, S_FINISH
	} state_t;

	state_t   state_q;
	cnt_t     cnt_q, t_q;
	word_t    n_q, a_q, rem_q, u_q, x_q;
	verdict_t res_q, verdict_q;
	logic     rsp_valid_q;

	logic           mm_start, mm_done;
	word_t          mm_y, mm_res, nm1;
	logic [WIDTH:0] rsh;

	assign nm1       = n_q - word_t'(1);
	assign rsh       = {rem_q, a_q[WIDTH-1]};
	assign mm_start  = (state_q == S_POW_SQ) || (state_q == S_POW_MUL) ||
		((state_q == S_SQ_CHK) && (t_q != '0));
	assign mm_y      = (state_q == S_POW_MUL) ? rem_q : x_q;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign verdict   = verdict_q;

	mrw_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.x      (x_q),
		.y      (mm_y),
		.n      (n_q),
		.done   (mm_done),
		.result (mm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
			t_q         <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						n_q <= candidate;
						a_q <= witness;
						if (!candidate[0] || candidate == word_t'(1)) begin
							res_q   <= VERDICT_REJECT;
							state_q <= S_FINISH;
						end else begin
							rem_q   <= '0;
							cnt_q   <= cnt_t'(WIDTH - 1);
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					rem_q <= (rsh >= {1'b0, n_q}) ? word_t'(rsh - {1'b0, n_q}) : rsh[WIDTH-1:0];
					a_q   <= {a_q[WIDTH-2:0], 1'b0};
					if (cnt_q == '0) begin
						u_q     <= nm1;
						t_q     <= '0;
						state_q <= S_SPLIT;
					end else begin
						cnt_q <= cnt_q - cnt_t'(1);
					end
				end
				S_SPLIT: begin
					if (!u_q[0]) begin
						u_q <= {1'b0, u_q[WIDTH-1:1]};
						t_q <= t_q + cnt_t'(1);
					end else begin
						x_q     <= word_t'(1);
						cnt_q   <= cnt_t'(WIDTH - 1);
						state_q <= S_POW_SQ;
					end
				end
				S_POW_SQ: state_q <= S_POW_SQ_W;
				S_POW_MUL: state_q <= S_POW_MUL_W;
				S_POW_SQ_W, S_POW_MUL_W: begin
					if (mm_done) begin
						x_q <= mm_res;
						if (state_q == S_POW_SQ_W && u_q[WIDTH-1]) begin
							state_q <= S_POW_MUL;
						end else begin
							u_q <= {u_q[WIDTH-2:0], 1'b0};
							if (cnt_q == '0) begin
								state_q <= S_SQ_CHK;
							end else begin
								cnt_q   <= cnt_q - cnt_t'(1);
								state_q <= S_POW_SQ;
							end
						end
					end
				end
				S_SQ_CHK: begin
					if (t_q == '0) begin
						res_q   <= (x_q == word_t'(1)) ? VERDICT_PRIME : VERDICT_COMPOSITE;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SQ_W;
					end
				end
				S_SQ_W: begin
					if (mm_done) begin
						if (mm_res == word_t'(1) && x_q != word_t'(1) && x_q != nm1) begin
							res_q   <= VERDICT_COMPOSITE;
							state_q <= S_FINISH;
						end else begin
							x_q     <= mm_res;
							t_q     <= t_q - cnt_t'(1);
							state_q <= S_SQ_CHK;
						end
					end
				end
				S_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						verdict_q   <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// multiplier finishes only while the sequencer waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == S_POW_SQ_W || state_q == S_POW_MUL_W || state_q == S_SQ_W))
		else $error("multiplier done outside a wait state");

	// new verdict only comes from the finish state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FINISH))
		else $error("verdict raised outside finish");

	// remainder stays reduced during witness reduction
	a_rem_lt_n: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REDUCE) |-> (rem_q < n_q))
		else $error("remainder not reduced");

	// verdict code is never the unused value
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (verdict_q != 2'd3))
		else $error("illegal verdict code");

endmodule

FILE: rtl/core/mrw_modmul.sv
// mrw_modmul: bit-serial modular multiplier, x * y mod n, one multiplier
// bit per cycle, with an added add step for each set bit; depends on mrw_pkg
module mrw_modmul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mrw_pkg::word_t x,
	input  mrw_pkg::word_t y,
	input  mrw_pkg::word_t n,
	output logic          done,
	output mrw_pkg::word_t result
);
	import mrw_pkg::*;

	logic  busy_q, phase_q, done_q;
	cnt_t  cnt_q;
	word_t acc_q, x_q, y_q, n_q;
	word_t dbl, addx;

	assign dbl    = mrw_add_mod(acc_q, acc_q, n_q);
	assign addx   = mrw_add_mod(acc_q, x_q, n_q);
	assign done   = done_q;
	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= cnt_t'(WIDTH - 1);
			end else if (busy_q) begin
				if (!phase_q && y_q[WIDTH-1]) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - cnt_t'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			n_q   <= n;
		end else if (busy_q) begin
			if (!phase_q) begin
				acc_q <= dbl;
				if (!y_q[WIDTH-1]) begin
					y_q <= {y_q[WIDTH-2:0], 1'b0};
				end
			end else begin
				acc_q <= addx;
				y_q   <= {y_q[WIDTH-2:0], 1'b0};
			end
		end
	end

endmodule
